FILE: src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define GCD_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// property that is also checked while reset is asserted
`define GCD_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

FILE: src/gcd_pkg.sv
// ----------------------------------------------------------------------------
// gcd_pkg
// shared types, constants and helper functions of the great-circle datapath
// ----------------------------------------------------------------------------
package gcd_pkg;

	localparam int CORDIC_STAGES_DEF = 24;

	// angle inside the datapath, signed q.30 radians
	typedef logic signed [35:0] ang_t;
	// sine / cosine / product value, signed q.30
	typedef logic signed [31:0] sc_t;
	// q.30 product result
	typedef logic signed [32:0] prod_t;

	localparam ang_t PI_Q30      = 36'sd3373259426;
	localparam ang_t TWO_PI_Q30  = 36'sd6746518852;
	localparam ang_t HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;

	localparam logic [31:0] ATAN_Q30 [32] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001, 32'h00000000
	};

	// number of cordic stages actually built
	function automatic int cordic_count(input int n);
		return (n > 32) ? 32 : n;
	endfunction

	// one step of bringing an angle into [-pi, pi]
	function automatic ang_t reduce_step(input ang_t a);
		if (a > PI_Q30) begin
			return a - TWO_PI_Q30;
		end else if (a < -PI_Q30) begin
			return a + TWO_PI_Q30;
		end else begin
			return a;
		end
	endfunction

	// q.30 product, floor shift
	function automatic prod_t mulq(input prod_t a, input prod_t b);
		logic signed [65:0] p;
		p = 66'(a) * 66'(b);
		return p[62:30];
	endfunction

endpackage

FILE: src/gcd_sincos.sv
// ----------------------------------------------------------------------------
// gcd_sincos
// pipelined range reduction and rotation cordic giving sine and cosine
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic en,
	input  ang_t ang,
	output sc_t  sin_val,
	output sc_t  cos_val
);
	localparam int NST = cordic_count(CORDIC_STAGES);

	ang_t red_q [4];
	ang_t fold_ang;
	logic fold_neg;

	logic signed [33:0] x_q [NST+1];
	logic signed [33:0] y_q [NST+1];
	logic signed [33:0] z_q [NST+1];
	logic               neg_q [NST+1];
	logic signed [33:0] x_out;

	// four reduction steps, one per stage
	always_ff @(posedge clk) begin
		if (en) begin
			red_q[0] <= reduce_step(ang);
			for (int k = 1; k < 4; k++) begin
				red_q[k] <= reduce_step(red_q[k-1]);
			end
		end
	end

	// mirror into [-pi/2, pi/2]
	always_comb begin
		fold_ang = red_q[3];
		fold_neg = 1'b0;
		if (red_q[3] > HALF_PI_Q30) begin
			fold_ang = PI_Q30 - red_q[3];
			fold_neg = 1'b1;
		end else if (red_q[3] < -HALF_PI_Q30) begin
			fold_ang = -PI_Q30 - red_q[3];
			fold_neg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0]   <= GAIN_Q30;
			y_q[0]   <= '0;
			z_q[0]   <= 34'(fold_ang);
			neg_q[0] <= fold_neg;
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_stage
		localparam logic signed [33:0] AT = 34'(ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				neg_q[i+1] <= neg_q[i];
				if (z_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - AT;
				end else begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + AT;
				end
			end
		end
	end

	assign x_out   = neg_q[NST] ? -x_q[NST] : x_q[NST];
	assign sin_val = y_q[NST][31:0];
	assign cos_val = x_out[31:0];

endmodule

FILE: src/gcd_isqrt.sv
// ----------------------------------------------------------------------------
// gcd_isqrt
// integer square root, one result bit per pipeline stage
// ----------------------------------------------------------------------------
module gcd_isqrt import gcd_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] val,
	output logic [31:0] root
);
	logic [63:0] v_q  [32];
	logic [63:0] r_q  [32];
	logic [63:0] v_in [32];
	logic [63:0] r_in [32];

	assign v_in[0] = val;
	assign r_in[0] = '0;

	for (genvar k = 0; k < 32; k++) begin : g_step
		localparam logic [63:0] BIT = 64'(1) << (62 - 2 * k);
		logic [63:0] trial;
		if (k > 0) begin : g_link
			assign v_in[k] = v_q[k-1];
			assign r_in[k] = r_q[k-1];
		end
		assign trial = r_in[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in[k] >= trial) begin
					v_q[k] <= v_in[k] - trial;
					r_q[k] <= (r_in[k] >> 1) + BIT;
				end else begin
					v_q[k] <= v_in[k];
					r_q[k] <= r_in[k] >> 1;
				end
			end
		end
	end

	assign root = r_q[31][31:0];

endmodule

FILE: src/gcd_atan2.sv
// ----------------------------------------------------------------------------
// gcd_atan2
// vectoring cordic giving the central angle, clamped to [0, pi]
// ----------------------------------------------------------------------------
module gcd_atan2 import gcd_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        top,
	input  logic signed [33:0] bottom,
	output logic [31:0]        angle
);
	localparam int NST = cordic_count(CORDIC_STAGES);

	logic signed [35:0] x_q [NST+1];
	logic signed [35:0] y_q [NST+1];
	logic signed [34:0] z_q [NST+1];
	logic [31:0]        ang_q;

	// left half plane: rotate by a quarter turn first
	always_ff @(posedge clk) begin
		if (en) begin
			if (bottom < 0) begin
				x_q[0] <= 36'(top);
				y_q[0] <= -36'(bottom);
				z_q[0] <= 35'(HALF_PI_Q30);
			end else begin
				x_q[0] <= 36'(bottom);
				y_q[0] <= 36'(top);
				z_q[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < NST; i++) begin : g_stage
		localparam logic signed [34:0] AT = 35'(ATAN_Q30[i]);
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_q[i] >= 0) begin
					x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] + AT;
				end else begin
					x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
					y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
					z_q[i+1] <= z_q[i] - AT;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (z_q[NST] < 0) begin
				ang_q <= '0;
			end else if (z_q[NST] > 35'(PI_Q30)) begin
				ang_q <= 32'(PI_Q30);
			end else begin
				ang_q <= z_q[NST][31:0];
			end
		end
	end

	assign angle = ang_q;

endmodule

FILE: src/great_circle_distance_top.sv
// ----------------------------------------------------------------------------
// great_circle_distance_top
// pipeline: one rotation cordic and one vectoring cordic in series, the
//   32-stage square root, the range reduction and the product stages
// throughput: one transfer per cycle; the whole pipeline stalls only while
//   a finished result waits on the output
// reset: arst_n clears the valid bits at once; payload registers keep data
// ----------------------------------------------------------------------------
module great_circle_distance_top import gcd_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [31:0]        radius,
	input  logic signed [31:0] first_latitude,
	input  logic signed [31:0] second_latitude,
	input  logic signed [31:0] first_longitude,
	input  logic signed [31:0] second_longitude,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [33:0]        distance
);
	localparam int NST  = cordic_count(CORDIC_STAGES);
	// radius delay from the input stage to the final multiply
	localparam int RDLY = 2 * NST + 44;
	localparam int LAT  = 2 * NST + 47;

	// pipeline advance: everything moves unless the output holds a result that is not taken
	logic en;
	logic [LAT-1:0] vld_q;

	// input stage
	logic [31:0] rad_s1;
	ang_t lat1_s1, lat2_s1, dlon_s1;
	logic signed [33:0] dlon_diff, dlon_abs;

	// sine / cosine
	sc_t s1v, c1v, s2v, c2v, sdv, cdv;

	// product stages
	prod_t c2sd_s2, c1s2_s2, s1c2_s2, s1s2_s2, c1c2_s2;
	sc_t   cd_s2;
	prod_t a_s3, c1s2_s3, s1s2_s3, t1_s3, t2_s3;
	prod_t a_s4;
	logic signed [33:0] b_s4, bot_s4;
	logic signed [65:0] asq_full;
	logic signed [67:0] bsq_full;
	logic [63:0] asq_s5, bsq_s5;
	logic signed [33:0] bot_s5;
	logic [63:0] sum_s6;
	logic signed [33:0] bot_s6;
	logic signed [33:0] bot_q [32];

	logic [31:0] root;
	logic [31:0] angle;
	logic [31:0] rad_q [RDLY];
	logic [63:0] prod_s7;
	logic [64:0] rnd;
	logic [33:0] dist_s8;

	assign en       = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;

	// valid bits follow the data through every stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// angles to q.30; longitude difference taken as magnitude
	assign dlon_diff = 34'(first_longitude) - 34'(second_longitude);
	assign dlon_abs  = (dlon_diff < 0) ? -dlon_diff : dlon_diff;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= radius;
			lat1_s1 <= 36'(first_latitude) <<< 2;
			lat2_s1 <= 36'(second_latitude) <<< 2;
			dlon_s1 <= 36'(dlon_abs) <<< 2;
		end
	end

	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat1 (
		.clk(clk), .en(en), .ang(lat1_s1), .sin_val(s1v), .cos_val(c1v)
	);
	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_lat2 (
		.clk(clk), .en(en), .ang(lat2_s1), .sin_val(s2v), .cos_val(c2v)
	);
	gcd_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_dlon (
		.clk(clk), .en(en), .ang(dlon_s1), .sin_val(sdv), .cos_val(cdv)
	);

	// first products of the vincenty terms
	always_ff @(posedge clk) begin
		if (en) begin
			c2sd_s2 <= mulq(33'(c2v), 33'(sdv));
			c1s2_s2 <= mulq(33'(c1v), 33'(s2v));
			s1c2_s2 <= mulq(33'(s1v), 33'(c2v));
			s1s2_s2 <= mulq(33'(s1v), 33'(s2v));
			c1c2_s2 <= mulq(33'(c1v), 33'(c2v));
			cd_s2   <= cdv;
		end
	end

	// second products with cos dlon
	always_ff @(posedge clk) begin
		if (en) begin
			a_s3    <= c2sd_s2;
			c1s2_s3 <= c1s2_s2;
			s1s2_s3 <= s1s2_s2;
			t1_s3   <= mulq(s1c2_s2, 33'(cd_s2));
			t2_s3   <= mulq(c1c2_s2, 33'(cd_s2));
		end
	end

	// numerator terms and denominator
	always_ff @(posedge clk) begin
		if (en) begin
			a_s4   <= a_s3;
			b_s4   <= 34'(c1s2_s3) - 34'(t1_s3);
			bot_s4 <= 34'(s1s2_s3) + 34'(t2_s3);
		end
	end

	assign asq_full = 66'(a_s4) * 66'(a_s4);
	assign bsq_full = 68'(b_s4) * 68'(b_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			asq_s5 <= asq_full[63:0];
			bsq_s5 <= bsq_full[63:0];
			bot_s5 <= bot_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s6 <= asq_s5 + bsq_s5;
			bot_s6 <= bot_s5;
		end
	end

	gcd_isqrt u_isqrt (
		.clk(clk), .en(en), .val(sum_s6), .root(root)
	);

	// denominator waits alongside the square root
	always_ff @(posedge clk) begin
		if (en) begin
			bot_q[0] <= bot_s6;
			for (int k = 1; k < 32; k++) begin
				bot_q[k] <= bot_q[k-1];
			end
		end
	end

	gcd_atan2 #(.CORDIC_STAGES(CORDIC_STAGES)) u_atan2 (
		.clk(clk), .en(en), .top(root), .bottom(bot_q[31]), .angle(angle)
	);

	// radius waits for the central angle
	always_ff @(posedge clk) begin
		if (en) begin
			rad_q[0] <= rad_s1;
			for (int k = 1; k < RDLY; k++) begin
				rad_q[k] <= rad_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s7 <= 64'(rad_q[RDLY-1]) * 64'(angle);
		end
	end

	// round half up to q26.8 and saturate
	assign rnd = 65'(prod_s7) + (65'(1) << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			dist_s8 <= rnd[64] ? '1 : rnd[63:30];
		end
	end

	assign out_valid = vld_q[LAT-1];
	assign distance  = dist_s8;

endmodule

FILE: src/gcd_checker.sv
// ----------------------------------------------------------------------------
// gcd_checker
// port-level checks of the great-circle distance pipeline
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [31:0]        radius,
	input logic signed [31:0] first_latitude,
	input logic signed [31:0] second_latitude,
	input logic signed [31:0] first_longitude,
	input logic signed [31:0] second_longitude,
	input logic               out_valid,
	input logic               out_ready,
	input logic [33:0]        distance
);
	// no result shows while reset is held
	`GCD_ASSERT_ALWAYS(a_no_out_in_reset, clk, !arst_n |-> !out_valid)

	// a waiting result holds its value
	`GCD_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(distance))

	// a stalled output stalls the input side too
	`GCD_ASSERT(a_stall_back, clk, arst_n, out_valid && !out_ready |-> !in_ready)

	// an empty output never blocks the input
	`GCD_ASSERT(a_free_flow, clk, arst_n, !out_valid |-> in_ready)

endmodule

bind great_circle_distance_top gcd_checker u_gcd_checker (.*);
